// ===== design/ccls_pkg.sv =====
package ccls_pkg;

  localparam int PERIOD_W  = 16;
  localparam int SHARE_W   = 8;
  localparam int IDX_W     = 4;
  localparam int CLASS_W   = 4;
  localparam int DIST_W    = 18;
  localparam int RAD2_W    = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_TIMEOUT = 16'hFFFF;
  localparam logic [PERIOD_W-1:0] THRESH_RESET   = 16'hFFFF;
  localparam logic [7:0]          RADIUS_EMPTY   = 8'hFF;
  localparam logic [SHARE_W-1:0]  SHARE_MAX      = 8'hFF;

  localparam logic KIND_CLASSIFY = 1'b0;
  localparam logic KIND_WRITE    = 1'b1;

  typedef struct packed {
    logic [7:0] radius;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] label;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                kind;
    logic [PERIOD_W-1:0] period_clear;
    logic [PERIOD_W-1:0] period_red;
    logic [PERIOD_W-1:0] period_green;
    logic [PERIOD_W-1:0] period_blue;
    logic [IDX_W-1:0]    entry_index;
    logic [7:0]          entry_radius;
    logic [7:0]          entry_red;
    logic [7:0]          entry_green;
    logic [7:0]          entry_blue;
    logic [7:0]          entry_label;
  } in_item_t;

  typedef struct packed {
    logic               lit_enough;
    logic               found;
    logic [IDX_W-1:0]   region_number;
    logic [CLASS_W-1:0] class_code;
    logic [SHARE_W-1:0] share_red;
    logic [SHARE_W-1:0] share_green;
    logic [SHARE_W-1:0] share_blue;
  } out_item_t;

endpackage

// ===== design/ccls_ifs.sv =====
interface ccls_in_if;
  import ccls_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ccls_out_if;
  import ccls_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/ccls_ram.sv =====
module ccls_ram #(
  parameter int  WIDTH = 40,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/color_region_classifier_core.sv =====
// channel   | dir | handshake           | beat
// ----------+-----+---------------------+---------------------------------------
// in_ch     | in  | valid/ready         | classify sample or table entry write
// out_ch    | out | valid/ready         | one result per input beat
// cfg_*     | in  | cfg_we, no stall    | light_threshold (16 bits)
//
// A write beat goes straight to the emit state. A lit classify beat runs
// three parallel restoring dividers, then one table read a cycle over the
// min(REGION_COUNT,16) entries via a 2-stage distance pipe to the first hit;
// an unlit beat skips both. One beat in flight; in_ch.ready is low
// while it works. A stalled result sits in the output register while the next
// beat is taken. Reset (synchronous) marks every table entry empty.
module color_region_classifier_core #(
  parameter int REGION_COUNT = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ccls_in_if.sink                   in_ch,
  ccls_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [ccls_pkg::PERIOD_W-1:0] cfg_wdata
);
  import ccls_pkg::*;

  localparam int TBL_DEPTH = (REGION_COUNT < 16) ? REGION_COUNT : 16;
  localparam int AW        = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int CW        = $clog2(TBL_DEPTH + 1);
  localparam int LANES     = 3;
  localparam int NUM_W     = PERIOD_W + SHARE_W + 1;
  localparam int DSH_W     = PERIOD_W + SHARE_W - 1;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SCAN, S_EMIT} st_t;

  function automatic logic [RAD2_W-1:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return RAD2_W'(d) * RAD2_W'(d);
  endfunction

  st_t                st_r;
  logic [PERIOD_W-1:0] thr_r;
  logic [TBL_DEPTH-1:0] vld_r;
  logic [2:0]         stp_r;
  logic [CW-1:0]      cnt_r;
  logic               p1_v_r;
  logic [AW-1:0]      p1_idx_r;
  logic               p2_v_r;
  logic [AW-1:0]      p2_idx_r;
  logic [DIST_W-1:0]  dist_r;
  logic [RAD2_W-1:0]  rad2_r;
  logic               empty_r;
  logic [7:0]         lbl_r;
  logic               lit_r;
  logic               found_r;
  logic [IDX_W-1:0]   region_r;
  logic [CLASS_W-1:0] class_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [NUM_W-1:0]   rem_r [LANES];
  logic [DSH_W-1:0]   dsh_r [LANES];
  logic [SHARE_W-1:0] q_r   [LANES];
  logic               sat_r [LANES];

  logic [PERIOD_W-1:0] per_c  [LANES];
  logic [NUM_W-1:0]    num_c  [LANES];
  logic                sat_c  [LANES];
  logic                ge_c   [LANES];
  logic [SHARE_W-1:0]  share_c[LANES];

  logic        accept;
  logic        lit_c;
  logic        wr_ok;
  logic        ram_we;
  logic [AW-1:0] raddr;
  entry_t      wentry;
  entry_t      rentry;
  logic [ENTRY_W-1:0] rdata;
  logic        issue;
  logic        empty_c;
  logic [DIST_W-1:0] dist_c;
  logic        hit_c;
  logic        emit;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign emit = (st_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  assign lit_c = (in_ch.data.period_clear < thr_r)
              && (in_ch.data.period_red   != PERIOD_TIMEOUT)
              && (in_ch.data.period_green != PERIOD_TIMEOUT)
              && (in_ch.data.period_blue  != PERIOD_TIMEOUT)
              && (in_ch.data.period_red   != '0)
              && (in_ch.data.period_green != '0)
              && (in_ch.data.period_blue  != '0);

  assign per_c[0] = in_ch.data.period_red;
  assign per_c[1] = in_ch.data.period_green;
  assign per_c[2] = in_ch.data.period_blue;

  // round(256*clear/colour): numerator gets half the divisor, saturation
  // is decided up front, then one quotient bit per cycle.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num_c[l]   = {1'b0, in_ch.data.period_clear, 8'h00}
                 + NUM_W'(per_c[l][PERIOD_W-1:1]);
      sat_c[l]   = num_c[l] >= {1'b0, per_c[l], 8'h00};
      ge_c[l]    = rem_r[l] >= {2'b00, dsh_r[l]};
      share_c[l] = sat_r[l] ? SHARE_MAX : q_r[l];
    end
  end

  assign wr_ok  = {1'b0, in_ch.data.entry_index} < (IDX_W+1)'(TBL_DEPTH);
  assign ram_we = accept && (in_ch.data.kind == KIND_WRITE) && wr_ok;
  assign wentry = '{radius: in_ch.data.entry_radius, red: in_ch.data.entry_red,
                    green: in_ch.data.entry_green, blue: in_ch.data.entry_blue,
                    label: in_ch.data.entry_label};

  assign issue = (st_r == S_SCAN) && (cnt_r != CW'(TBL_DEPTH));
  assign raddr = cnt_r[AW-1:0];

  ccls_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.data.entry_index[AW-1:0]),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rentry  = entry_t'(rdata);
  assign empty_c = !vld_r[p1_idx_r] || (rentry.radius == RADIUS_EMPTY);
  assign dist_c  = DIST_W'(sq_diff(share_c[0], rentry.red))
                 + DIST_W'(sq_diff(share_c[1], rentry.green))
                 + DIST_W'(sq_diff(share_c[2], rentry.blue));
  assign hit_c   = p2_v_r && !empty_r && (dist_r < DIST_W'(rad2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      thr_r       <= THRESH_RESET;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (out_ch.ready && !emit) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        vld_r[in_ch.data.entry_index[AW-1:0]] <= 1'b1;
      end

      unique case (st_r)
        S_IDLE: begin
          if (accept) begin
            found_r  <= 1'b0;
            region_r <= '0;
            class_r  <= '0;
            if (in_ch.data.kind == KIND_WRITE) begin
              lit_r <= 1'b0;
              st_r  <= S_EMIT;
            end else begin
              lit_r <= lit_c;
              stp_r <= '0;
              for (int l = 0; l < LANES; l++) begin
                rem_r[l] <= num_c[l];
                dsh_r[l] <= {per_c[l], 7'b0};
                sat_r[l] <= sat_c[l];
                q_r[l]   <= '0;
              end
              st_r <= lit_c ? S_DIV : S_EMIT;
            end
          end
        end
        S_DIV: begin
          for (int l = 0; l < LANES; l++) begin
            if (ge_c[l]) begin
              rem_r[l] <= rem_r[l] - {2'b00, dsh_r[l]};
            end
            q_r[l]   <= {q_r[l][SHARE_W-2:0], ge_c[l]};
            dsh_r[l] <= dsh_r[l] >> 1;
          end
          stp_r <= stp_r + 3'd1;
          if (stp_r == 3'd7) begin
            cnt_r  <= '0;
            p1_v_r <= 1'b0;
            p2_v_r <= 1'b0;
            st_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          p1_v_r   <= issue && !hit_c;
          p1_idx_r <= raddr;
          if (issue) begin
            cnt_r <= cnt_r + CW'(1);
          end
          p2_v_r   <= p1_v_r && !hit_c;
          p2_idx_r <= p1_idx_r;
          dist_r   <= dist_c;
          rad2_r   <= RAD2_W'(rentry.radius) * RAD2_W'(rentry.radius);
          empty_r  <= empty_c;
          lbl_r    <= rentry.label;
          if (hit_c) begin
            found_r  <= 1'b1;
            region_r <= IDX_W'(p2_idx_r);
            class_r  <= lbl_r[CLASS_W-1:0];
            st_r     <= S_EMIT;
          end else if (!issue && !p1_v_r && !p2_v_r) begin
            st_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            out_valid_r              <= 1'b1;
            out_data_r.lit_enough    <= lit_r;
            out_data_r.found         <= found_r;
            out_data_r.region_number <= region_r;
            out_data_r.class_code    <= class_r;
            out_data_r.share_red     <= lit_r ? share_c[0] : '0;
            out_data_r.share_green   <= lit_r ? share_c[1] : '0;
            out_data_r.share_blue    <= lit_r ? share_c[2] : '0;
            st_r                     <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ccls_pkg::*;

  class region_match_predictor;
    entry_t      regions[16];
    logic [15:0] threshold;
    out_item_t   expected_results[$];
    int          errors;

    function new();
      threshold = THRESH_RESET;
      errors = 0;
      foreach (regions[i]) begin
        regions[i] = '0;
        regions[i].radius = RADIUS_EMPTY;
      end
    endfunction

    function logic [7:0] share(int unsigned clr, int unsigned colour);
      int unsigned p;
      p = (clr * 256 + colour / 2) / colour;
      return (p > 255) ? SHARE_MAX : p[7:0];
    endfunction

    function int unsigned sq_gap(int unsigned a, int unsigned b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
    endfunction

    function void predict_beat(in_item_t it);
      out_item_t   r;
      int unsigned gap_sum;
      int unsigned rad2;
      r = '0;
      if (it.kind == KIND_WRITE) begin
        regions[it.entry_index] = {it.entry_radius, it.entry_red, it.entry_green,
                                   it.entry_blue, it.entry_label};
      end else if (it.period_clear < threshold &&
                   it.period_red != PERIOD_TIMEOUT && it.period_red != 0 &&
                   it.period_green != PERIOD_TIMEOUT && it.period_green != 0 &&
                   it.period_blue != PERIOD_TIMEOUT && it.period_blue != 0) begin
        r.lit_enough  = 1'b1;
        r.share_red   = share(it.period_clear, it.period_red);
        r.share_green = share(it.period_clear, it.period_green);
        r.share_blue  = share(it.period_clear, it.period_blue);
        for (int i = 0; i < 16; i++) begin
          if (regions[i].radius == RADIUS_EMPTY) continue;
          rad2 = regions[i].radius * regions[i].radius;
          gap_sum = sq_gap(r.share_red, regions[i].red)
                  + sq_gap(r.share_green, regions[i].green)
                  + sq_gap(r.share_blue, regions[i].blue);
          if (gap_sum < rad2) begin
            r.found = 1'b1;
            r.region_number = 4'(i);
            r.class_code = regions[i].label[3:0];
            break;
          end
        end
      end
      expected_results.push_back(r);
    endfunction

    function void field_check(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got %h", $time, got);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      field_check("lit_enough", exp.lit_enough, got.lit_enough);
      field_check("found", exp.found, got.found);
      field_check("region_number", exp.region_number, got.region_number);
      field_check("class_code", exp.class_code, got.class_code);
      field_check("share_red", exp.share_red, got.share_red);
      field_check("share_green", exp.share_green, got.share_green);
      field_check("share_blue", exp.share_blue, got.share_blue);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  ccls_in_if  in_ch();
  ccls_out_if out_ch();

  region_match_predictor predictor = new();

  color_region_classifier_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) predictor.predict_beat(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) predictor.check_result(out_ch.data);
  end

  function automatic in_item_t mk_sample(logic [15:0] pc, logic [15:0] pr,
                                         logic [15:0] pg, logic [15:0] pb);
    in_item_t it;
    it = '0;
    it.kind = KIND_CLASSIFY;
    it.period_clear = pc;
    it.period_red = pr;
    it.period_green = pg;
    it.period_blue = pb;
    return it;
  endfunction

  function automatic in_item_t mk_entry(logic [3:0] idx, logic [7:0] rad, logic [7:0] r,
                                        logic [7:0] g, logic [7:0] b, logic [7:0] lab);
    in_item_t it;
    it = '0;
    it.kind = KIND_WRITE;
    it.entry_index = idx;
    it.entry_radius = rad;
    it.entry_red = r;
    it.entry_green = g;
    it.entry_blue = b;
    it.entry_label = lab;
    return it;
  endfunction

  // period that lands the proportion near a sphere centre
  function automatic logic [15:0] period_for(int unsigned clr, int unsigned centre);
    int          t;
    int unsigned tu;
    int unsigned p;
    t = int'(centre) + int'($urandom_range(8)) - 4;
    if (t < 1) t = 1;
    if (t > 255) t = 255;
    tu = t;
    p = (clr * 256 + tu / 2) / tu;
    if (p < 1) p = 1;
    if (p > 65534) p = 65534;
    return p[15:0];
  endfunction

  function automatic logic [15:0] odd_period(logic [15:0] p);
    case ($urandom_range(5))
      0: return PERIOD_TIMEOUT;
      1: return '0;
      default: return p;
    endcase
  endfunction

  function automatic in_item_t random_beat();
    in_item_t    it;
    logic [127:0] noise;
    int unsigned pick;
    int unsigned clr;
    int unsigned k;
    noise = {$urandom(), $urandom(), $urandom(), $urandom()};
    it = noise[$bits(in_item_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 20) begin
      it.kind = KIND_WRITE;
      case ($urandom_range(9))
        0: it.entry_radius = 8'd0;
        1: it.entry_radius = RADIUS_EMPTY;
        2: it.entry_radius = 8'($urandom());
        default: it.entry_radius = 8'($urandom_range(8, 90));
      endcase
    end else if (pick < 80) begin
      it.kind = KIND_CLASSIFY;
      k = $urandom_range(15);
      clr = $urandom_range(1, 3000);
      it.period_clear = 16'(clr);
      it.period_red   = period_for(clr, predictor.regions[k].red);
      it.period_green = period_for(clr, predictor.regions[k].green);
      it.period_blue  = period_for(clr, predictor.regions[k].blue);
    end else begin
      it.kind = KIND_CLASSIFY;
      it.period_clear = odd_period(it.period_clear);
      it.period_red   = odd_period(it.period_red);
      it.period_green = odd_period(it.period_green);
      it.period_blue  = odd_period(it.period_blue);
    end
    return it;
  endfunction

  task automatic send_beat(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (predictor.expected_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_threshold(logic [15:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    predictor.threshold = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_beat(random_beat());
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_beat(mk_sample(16'd1000, 16'd2000, 16'd2000, 16'd2000));
    send_beat(mk_entry(4'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'hFF));
    send_beat(mk_entry(4'd1, 8'd20, 8'd128, 8'd128, 8'd128, 8'hA5));
    send_beat(mk_entry(4'd15, 8'd254, 8'd255, 8'd255, 8'd255, 8'h0F));
    send_beat(mk_entry(4'd3, RADIUS_EMPTY, 8'd0, 8'd0, 8'd0, 8'h03));
    send_beat(mk_sample(16'd1000, 16'd2000, 16'd2000, 16'd2000));
    send_beat(mk_sample(16'd0, 16'd1, 16'd1, 16'd1));
    send_beat(mk_sample(16'd65534, 16'd1, 16'd1, 16'd1));
    send_beat(mk_sample(16'd1000, PERIOD_TIMEOUT, 16'd2000, 16'd2000));
    send_beat(mk_sample(16'd1000, 16'd2000, 16'd0, 16'd2000));
    send_beat(mk_sample(16'd1000, 16'd2000, 16'd2000, PERIOD_TIMEOUT));
    send_beat(mk_sample(16'd1000, 16'd0, 16'd0, 16'd0));
    send_beat(mk_sample(PERIOD_TIMEOUT, 16'd2000, 16'd2000, 16'd2000));
    send_beat(mk_sample(PERIOD_TIMEOUT, PERIOD_TIMEOUT, PERIOD_TIMEOUT, PERIOD_TIMEOUT));
    send_beat(mk_entry(4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_beat(mk_sample(16'd65534, 16'd1, 16'd1, 16'd1));
    send_beat(mk_entry(4'd7, 8'd200, 8'd0, 8'd255, 8'd10, 8'h5A));
    send_beat(mk_sample(16'd1000, 16'd65534, 16'd1000, 16'd25600));
    send_beat(mk_sample(16'd1234, 16'd777, 16'd4321, 16'd99));

    set_threshold(16'hFFFF);
    run_phase(400, 0, 0);
    set_threshold(16'd4500);
    run_phase(350, 68, 0);
    set_threshold(16'd0);
    run_phase(100, 0, 68);
    set_threshold(16'($urandom_range(1000, 65535)));
    run_phase(350, 8, 8);
    set_threshold(16'd1);
    run_phase(50, 0, 0);
    set_threshold(16'hFFFF);
    run_phase(250, 0, 68);
    settle();

    if (predictor.errors == 0 && predictor.expected_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
